### hdl/scf_pkg.sv
// Shared types, constants and helpers for the snapshot compare filter.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

  // Number of tracked elements and the widths that follow from it
  localparam int ELEMENTS = 4096;
  localparam int AW       = $clog2(ELEMENTS);
  localparam int CNT_W    = $clog2(ELEMENTS + 1);

  // Fixed field widths
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 32;
  localparam int MCH_W  = 13;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_CONDITION    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SEARCH_VALUE = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ELEMENT_SIZE = 2'd2;

  // Element size codes
  localparam logic [1:0] SIZE_B8  = 2'd0;
  localparam logic [1:0] SIZE_B16 = 2'd1;
  localparam logic [1:0] SIZE_B32 = 2'd2;

  // Pass modes
  typedef enum logic [1:0] {
    COND_ANY = 2'd0,
    COND_EQ  = 2'd1,
    COND_INC = 2'd2,
    COND_DEC = 2'd3
  } cond_t;

  typedef struct packed {
    logic [IDX_W-1:0] element_index;
    logic [VAL_W-1:0] element_value;
    logic             first_of_pass;
    logic             last_of_pass;
  } in_t;

  typedef struct packed {
    logic             still_candidate;
    logic [MCH_W-1:0] pass_matches;
    logic             pass_done;
    logic             pass_skipped;
  } out_t;

  typedef struct packed {
    cond_t            cond;
    logic [VAL_W-1:0] search;
    logic [1:0]       esize;
  } cfg_t;

  // One memory word: candidate bit and snapshot
  typedef struct packed {
    logic             cand;
    logic [VAL_W-1:0] snap;
  } ent_t;

  typedef struct packed {
    logic hit;
    logic cand;
  } match_t;

  localparam ent_t ENT_RESET = '{cand: 1'b1, snap: '0};

  function automatic logic [VAL_W-1:0] size_mask(input logic [1:0] esize);
    logic [VAL_W-1:0] m;
    case (esize)
      SIZE_B8:  m = VAL_W'(32'h0000_00FF);
      SIZE_B16: m = VAL_W'(32'h0000_FFFF);
      default:  m = '1;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### hdl/scf_match.sv
// Compare unit: decides whether an element stays a candidate and counts.
`timescale 1ns / 1ps
`default_nettype none

module scf_match (
  input  scf_pkg::cfg_t              cfg,
  input  scf_pkg::ent_t              ent,
  input  logic [scf_pkg::VAL_W-1:0]  value,
  output scf_pkg::match_t            res
);

  logic [scf_pkg::VAL_W-1:0] mask;
  logic [scf_pkg::VAL_W-1:0] now_v;
  logic [scf_pkg::VAL_W-1:0] prev_v;
  logic                      cmp;

  assign mask   = scf_pkg::size_mask(cfg.esize);
  assign now_v  = value & mask;
  assign prev_v = ent.snap & mask;

  // Pick the comparison for the current pass mode
  always_comb begin
    unique case (cfg.cond)
      scf_pkg::COND_EQ:  cmp = (now_v == cfg.search);
      scf_pkg::COND_INC: cmp = (now_v > prev_v);
      scf_pkg::COND_DEC: cmp = (now_v < prev_v);
      default:           cmp = 1'b1;
    endcase
  end

  // Unconditional mode marks everything; compare modes only keep candidates
  always_comb begin
    if (cfg.cond == scf_pkg::COND_ANY) begin
      res.hit  = 1'b1;
      res.cand = 1'b1;
    end else if (ent.cand) begin
      res.hit  = cmp;
      res.cand = cmp;
    end else begin
      res.hit  = 1'b0;
      res.cand = 1'b0;
    end
  end

endmodule

`default_nettype wire

### hdl/snapshot_compare_filter.sv
// Input and memory read register into the evaluate stage, then into the output register.
// Throughput: one element per cycle while out_stall is low; the one read port and one
//   write port of the entry memory set that, bypassing writes to reads of the same index.
// Reset: synchronous, active low; after reset a sweep writes all ELEMENTS (4096) entries
//   back to snapshot zero, candidate one; in_stall stays high during the sweep while
//   configuration writes are still taken.
`timescale 1ns / 1ps
`default_nettype none

module snapshot_compare_filter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  scf_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output scf_pkg::out_t                out_data,
  input  logic                         cfg_we,
  input  logic [scf_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [scf_pkg::CFG_DW-1:0]   cfg_data
);

  // Entry memory: candidate bit and snapshot per element
  scf_pkg::ent_t mem [scf_pkg::ELEMENTS];

  scf_pkg::cfg_t                cfg_r;
  logic                         clr_busy_r;
  logic [scf_pkg::AW-1:0]       clr_addr_r;
  logic                         s1_valid_r, s1_valid_nxt;
  scf_pkg::in_t                 s1_data_r;
  scf_pkg::ent_t                rd_r;
  logic [scf_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         skip_r, skip_nxt;
  logic                         out_valid_r, out_valid_nxt;
  scf_pkg::out_t                out_data_r;

  logic                         in_acc;
  logic                         s1_adv;
  logic                         s1_we;
  logic [scf_pkg::AW-1:0]       rd_addr;
  logic [scf_pkg::AW-1:0]       s1_addr;
  logic                         in_range;
  logic [scf_pkg::CNT_W-1:0]    cnt_base;
  logic                         cand_out;
  scf_pkg::ent_t                wr_ent;
  scf_pkg::match_t              mres;

  // Handshake control
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  assign rd_addr  = scf_pkg::AW'(in_data.element_index);
  assign s1_addr  = scf_pkg::AW'(s1_data_r.element_index);
  assign in_range = (32'(s1_data_r.element_index) < 32'(scf_pkg::ELEMENTS));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cond   <= scf_pkg::COND_ANY;
      cfg_r.search <= '0;
      cfg_r.esize  <= scf_pkg::SIZE_B32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scf_pkg::CFG_CONDITION:    cfg_r.cond   <= scf_pkg::cond_t'(cfg_data[1:0]);
        scf_pkg::CFG_SEARCH_VALUE: cfg_r.search <= cfg_data[scf_pkg::VAL_W-1:0];
        scf_pkg::CFG_ELEMENT_SIZE: cfg_r.esize  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == scf_pkg::AW'(scf_pkg::ELEMENTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  scf_match u_match (
    .cfg   (cfg_r),
    .ent   (rd_r),
    .value (s1_data_r.element_value),
    .res   (mres)
  );

  // Evaluate stage: pass marks, count and write-back entry
  always_comb begin
    skip_nxt = skip_r;
    cnt_base = cnt_r;
    if (s1_data_r.first_of_pass) begin
      if (cnt_r == '0) begin
        skip_nxt = 1'b1;
      end else begin
        skip_nxt = 1'b0;
        cnt_base = '0;
      end
    end
    cnt_nxt = cnt_base;
    if (in_range && !skip_nxt && mres.hit &&
        (32'(cnt_base) < 32'(scf_pkg::ELEMENTS))) begin
      cnt_nxt = cnt_base + 1'b1;
    end
    wr_ent.cand = mres.cand;
    wr_ent.snap = s1_data_r.element_value;
    s1_we       = s1_adv && in_range && !skip_nxt;
    if (!in_range) begin
      cand_out = 1'b0;
    end else if (skip_nxt) begin
      cand_out = rd_r.cand;
    end else begin
      cand_out = mres.cand;
    end
  end

  // Memory write and registered read with bypass from the write port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= scf_pkg::ENT_RESET;
    end else if (s1_we) begin
      mem[s1_addr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (s1_we && (s1_addr == rd_addr)) begin
        rd_r <= wr_ent;
      end else begin
        rd_r <= mem[rd_addr];
      end
      s1_data_r <= in_data;
    end
  end

  // Stage and output valid tracking
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= scf_pkg::CNT_W'(scf_pkg::ELEMENTS);
      skip_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        cnt_r  <= cnt_nxt;
        skip_r <= skip_nxt;
      end
    end
  end

  // Output register: hold while stalled, load on advance
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.still_candidate <= cand_out;
      out_data_r.pass_matches    <= scf_pkg::MCH_W'(cnt_nxt);
      out_data_r.pass_done       <= s1_data_r.last_of_pass;
      out_data_r.pass_skipped    <= skip_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/scf_checker.sv
// Port-level checker for the snapshot compare filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module scf_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  scf_pkg::out_t                out_data
);

  // Reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Clearing sweep blocks input right after reset
  a_reset_stalls_in: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A skipped pass reports no matches
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pass_skipped |-> out_data.pass_matches == '0)
    else $error("skipped pass shows matches");

  // Count never passes the element total
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.pass_matches) <= 32'(scf_pkg::ELEMENTS))
    else $error("match count above element total");

endmodule

bind snapshot_compare_filter scf_checker u_scf_checker (.*);

`default_nettype wire
